@@ hw/rtl/rmat_pkg.sv @@
// Package for the R-MAT edge generator: widths, fixed-point constants, register indexes.
// No dependencies.
package rmat_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_SCALE = 32;
    localparam int PROB_W    = FRAC_BITS + 1;
    localparam int RAND_W    = FRAC_BITS;
    localparam int VERT_W    = MAX_SCALE;
    localparam int SCALE_W   = 6;
    localparam int LVL_W     = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 17;

    localparam logic [PROB_W-1:0] ONE_FX  = PROB_W'(1) << FRAC_BITS;
    localparam logic [PROB_W-1:0] K95_FX  = PROB_W'(((95 << FRAC_BITS) + 50) / 100);
    localparam logic [PROB_W-1:0] K10_FX  = PROB_W'(((10 << FRAC_BITS) + 50) / 100);
    localparam logic [33:0]       HALF_FX = 34'(1) << (FRAC_BITS - 1);

    localparam logic [CFG_IDX_W-1:0] REG_PROB_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROB_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROB_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROB_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd4;

    // quotient width: p' <= ~1.05, so p'<<F / sum fits in 35 bits
    localparam int DIVN_W = PROB_W + 1 + FRAC_BITS + 1;
    localparam int DIVD_W = PROB_W + 3;
    localparam int DCNT_W = 6;

    function automatic logic [PROB_W-1:0] sat_prob(input logic [PROB_W-1:0] p);
        return (p > ONE_FX) ? ONE_FX : p;
    endfunction

endpackage

@@ hw/rtl/rmat_div.sv @@
// Restoring divider, one quotient bit per cycle, rounds half up.
// Depends on rmat_pkg.
module rmat_div
    import rmat_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [PROB_W:0]     numer,
    input  logic [DIVD_W-1:0]   denom,
    output logic                done,
    output logic [PROB_W-1:0]   quot
);
    logic [DIVN_W-1:0] num_reg, num_next;
    logic [DIVD_W:0]   rem_reg, rem_next;
    logic [DIVN_W-1:0] q_reg, q_next;
    logic [DIVD_W-1:0] den_reg, den_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVD_W:0]   trial;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DIVD_W-1:0], num_reg[DIVN_W-1]};
        if (start)
        begin
            // (p<<F) + sum/2
            num_next  = DIVN_W'({numer, {FRAC_BITS{1'b0}}}) + DIVN_W'(denom >> 1);
            den_next  = denom;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = DCNT_W'(DIVN_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                q_next   = {q_reg[DIVN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[DIVN_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = (q_reg > DIVN_W'(ONE_FX)) ? ONE_FX : q_reg[PROB_W-1:0];
endmodule

@@ hw/rtl/rmat_edge_generator.sv @@
// R-MAT edge generator top level: config registers, level sequencer, shared multiplier.
// Depends on rmat_pkg and rmat_div.
//
// One input word is one recursion level; an edge takes scale_bits words and the
// result word follows the last one. The first level of an edge goes from the
// accept straight to the quadrant choice. Every later level runs a sequencer over
// one shared 17x17 multiplier (4 noise factors, then 4 products, in turn) and one
// bit-serial divider that renormalizes the four probabilities one after another,
// or zeroes all four when their sum is zero.
// Input ready is low while a level is in work and while a result word waits to
// be taken.
module rmat_edge_generator
    import rmat_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [RAND_W-1:0]    noise_a,
    input  logic [RAND_W-1:0]    noise_b,
    input  logic [RAND_W-1:0]    noise_c,
    input  logic [RAND_W-1:0]    noise_d,
    input  logic [RAND_W-1:0]    choice_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [VERT_W-1:0]    source_vertex,
    output logic [VERT_W-1:0]    dest_vertex,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_FACT   = 6'b000010,
        ST_PROD   = 6'b000100,
        ST_DIV    = 6'b001000,
        ST_CHOOSE = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [PROB_W-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [PROB_W-1:0] cur_reg [4];
    logic [PROB_W:0]   pp_reg [4];     // perturbed values
    logic [PROB_W-1:0] fac_reg [4];
    logic [RAND_W-1:0] noise_reg [4];
    logic [RAND_W-1:0] choice_reg;
    logic [1:0]        sel_reg;
    logic              div_wait_reg;
    logic [LVL_W-1:0]  lvl_reg;
    logic [VERT_W-1:0] src_reg, dst_reg;
    logic [5:0]        eff_scale;

    logic [PROB_W-1:0] mul_a, mul_b;
    logic [33:0]       mul_p, mul_r;
    logic [DIVD_W-1:0] sum;
    logic              div_start, div_done;
    logic [PROB_W-1:0] div_q;
    logic              in_acc;
    logic [PROB_W+1:0] cab, cabc;
    logic [VERT_W-1:0] bitv;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign source_vertex = src_reg;
    assign dest_vertex   = dst_reg;
    assign in_acc    = in_valid && in_ready;

    always_comb
    begin
        if (scale_reg == '0)
            eff_scale = 6'd1;
        else if (scale_reg > 6'(MAX_SCALE))
            eff_scale = 6'(MAX_SCALE);
        else
            eff_scale = scale_reg;
    end

    // shared multiplier: factor = K95 + rnd(K10*noise), then p' = rnd(p*factor)
    always_comb
    begin
        if (state_reg == ST_FACT)
        begin
            mul_a = K10_FX;
            mul_b = {1'b0, noise_reg[sel_reg]};
        end
        else
        begin
            mul_a = cur_reg[sel_reg];
            mul_b = fac_reg[sel_reg];
        end
        mul_p = 34'(mul_a) * 34'(mul_b);
        mul_r = (mul_p + HALF_FX) >> FRAC_BITS;
    end

    assign sum = DIVD_W'(pp_reg[0]) + DIVD_W'(pp_reg[1]) + DIVD_W'(pp_reg[2])
               + DIVD_W'(pp_reg[3]);
    assign div_start = (state_reg == ST_DIV) && !div_wait_reg && (sum != '0);

    rmat_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (pp_reg[sel_reg]),
        .denom (sum),
        .done  (div_done),
        .quot  (div_q)
    );

    assign cab  = (PROB_W+2)'(cur_reg[0]) + (PROB_W+2)'(cur_reg[1]);
    assign cabc = cab + (PROB_W+2)'(cur_reg[2]);
    assign bitv = VERT_W'(1) << (eff_scale - 6'd1 - lvl_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc)
                    state_next = (lvl_reg == '0) ? ST_CHOOSE : ST_FACT;
            ST_FACT:
                if (sel_reg == 2'd3)
                    state_next = ST_PROD;
            ST_PROD:
                if (sel_reg == 2'd3)
                    state_next = ST_DIV;
            ST_DIV:
                if ((sum == '0) || (div_done && sel_reg == 2'd3))
                    state_next = ST_CHOOSE;
            ST_CHOOSE:
                state_next = (lvl_reg + 6'd1 >= eff_scale) ? ST_OUT : ST_IDLE;
            ST_OUT:
                if (out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pa_reg       <= PROB_W'(36045);
            pb_reg       <= PROB_W'(6554);
            pc_reg       <= PROB_W'(6554);
            pd_reg       <= PROB_W'(16383);
            scale_reg    <= SCALE_W'(20);
            lvl_reg      <= '0;
            sel_reg      <= '0;
            div_wait_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_PROB_A: pa_reg <= cfg_data;
                    REG_PROB_B: pb_reg <= cfg_data;
                    REG_PROB_C: pc_reg <= cfg_data;
                    REG_PROB_D: pd_reg <= cfg_data;
                    REG_SCALE:  scale_reg <= cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_FACT, ST_PROD:
                    sel_reg <= sel_reg + 2'd1;
                ST_DIV:
                begin
                    if (div_start)
                        div_wait_reg <= 1'b1;
                    if (div_done)
                    begin
                        div_wait_reg <= 1'b0;
                        sel_reg      <= sel_reg + 2'd1;
                    end
                end
                ST_CHOOSE:
                begin
                    sel_reg <= '0;
                    lvl_reg <= (lvl_reg + 6'd1 >= eff_scale) ? '0 : lvl_reg + 6'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            noise_reg[0] <= noise_a;
            noise_reg[1] <= noise_b;
            noise_reg[2] <= noise_c;
            noise_reg[3] <= noise_d;
            choice_reg   <= choice_value;
            if (lvl_reg == '0)
            begin
                cur_reg[0] <= sat_prob(pa_reg);
                cur_reg[1] <= sat_prob(pb_reg);
                cur_reg[2] <= sat_prob(pc_reg);
                cur_reg[3] <= sat_prob(pd_reg);
                src_reg    <= '0;
                dst_reg    <= '0;
            end
        end
        if (state_reg == ST_FACT)
            fac_reg[sel_reg] <= K95_FX + mul_r[PROB_W-1:0];
        if (state_reg == ST_PROD)
            pp_reg[sel_reg] <= mul_r[PROB_W:0];
        if (state_reg == ST_DIV)
        begin
            if (sum == '0)
            begin
                cur_reg[0] <= '0;
                cur_reg[1] <= '0;
                cur_reg[2] <= '0;
                cur_reg[3] <= '0;
            end
            else if (div_done)
                cur_reg[sel_reg] <= div_q;
        end
        if (state_reg == ST_CHOOSE && lvl_reg < eff_scale)
        begin
            if ({2'b0, choice_reg} <= (PROB_W+2)'(cur_reg[0]))
                ;
            else if ({2'b0, choice_reg} <= cab)
                dst_reg <= dst_reg | bitv;
            else if ({2'b0, choice_reg} <= cabc)
                src_reg <= src_reg | bitv;
            else
            begin
                src_reg <= src_reg | bitv;
                dst_reg <= dst_reg | bitv;
            end
        end
    end
endmodule

@@ hw/rtl/rmat_checker.sv @@
// Port-level checks for the R-MAT edge generator.
// Depends on rmat_pkg; bound to rmat_edge_generator.
module rmat_checker
    import rmat_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [VERT_W-1:0] source_vertex,
    input logic [VERT_W-1:0] dest_vertex
);
    // no new word is taken while a result word waits
    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input ready while result pending");

    // a result only appears after work, never straight after accept
    a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid) else $error("result too early");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(source_vertex)
        && $stable(dest_vertex)) else $error("result word dropped or changed");
endmodule

bind rmat_edge_generator rmat_checker u_rmat_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .source_vertex (source_vertex),
    .dest_vertex   (dest_vertex)
);

@@ bench/tb_rmat_edge_generator.sv @@
// Self-checking bench for rmat_edge_generator: directed table, then random edges.
// Depends on rmat_pkg; carries its own model of the level recursion.
module tb_rmat_edge_generator;
    import rmat_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [RAND_W-1:0]    noise_a, noise_b, noise_c, noise_d, choice_value;
    logic                 out_valid;
    logic                 out_ready;
    logic [VERT_W-1:0]    source_vertex, dest_vertex;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    rmat_edge_generator uut (.*);

    typedef struct packed {
        logic [RAND_W-1:0] na, nb, nc, nd, ch;
        logic              chk;
        logic [VERT_W-1:0] src, dst;
    } level_row_t;

    typedef struct packed {
        logic [VERT_W-1:0] src, dst;
    } edge_t;

    // shadow registers and edge state
    logic [16:0] reg_a, reg_b, reg_c, reg_d;
    logic [5:0]  reg_scale;
    logic [16:0] p_a, p_b, p_c, p_d;
    logic [5:0]  lvl;
    logic [31:0] src_acc, dst_acc;

    edge_t       edge_q[$];
    edge_t       typed_q[$];   // typed expectations, parallel to edge_q (used only where typed_flag_q is set)
    logic        typed_flag_q[$];
    int          errors = 0;
    int          idle_cnt = 0;
    bit          calm;
    level_row_t  dir_rows[$];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [16:0] clamp_one(input logic [16:0] p);
        return (p > 17'h10000) ? 17'h10000 : p;
    endfunction

    function automatic logic [35:0] scale_prob(input logic [16:0] p, input logic [15:0] n);
        logic [35:0] k95, k10, f;
        k95 = ((36'd95 << 16) + 36'd50) / 36'd100;
        k10 = ((36'd10 << 16) + 36'd50) / 36'd100;
        f   = k95 + ((k10 * n + 36'h8000) >> 16);
        return (36'(p) * f + 36'h8000) >> 16;
    endfunction

    function automatic logic [16:0] renormalize(input logic [35:0] p, input logic [35:0] s);
        logic [55:0] q;
        if (s == 0)
            return 17'd0;
        q = ((56'(p) << 16) + 56'(s / 2)) / 56'(s);
        return (q > 56'h10000) ? 17'h10000 : 17'(q);
    endfunction

    // advance the edge state by one level word; returns 1 when an edge completes
    function automatic bit advance_level(input logic [15:0] na, nb, nc, nd, ch,
                                         output edge_t e);
        logic [5:0]  sc;
        logic [35:0] a, b, c, d, s;
        logic [17:0] ca, cab, cabc;
        logic [31:0] bitm;
        sc = (reg_scale < 1) ? 6'd1 : (reg_scale > 32 ? 6'd32 : reg_scale);
        if (lvl == 0)
        begin
            p_a = clamp_one(reg_a); p_b = clamp_one(reg_b);
            p_c = clamp_one(reg_c); p_d = clamp_one(reg_d);
            src_acc = 0; dst_acc = 0;
        end
        else
        begin
            a = scale_prob(p_a, na); b = scale_prob(p_b, nb);
            c = scale_prob(p_c, nc); d = scale_prob(p_d, nd);
            s = a + b + c + d;
            p_a = renormalize(a, s); p_b = renormalize(b, s);
            p_c = renormalize(c, s); p_d = renormalize(d, s);
        end
        if (lvl < sc)
        begin
            bitm = 32'd1 << (sc - 6'd1 - lvl);
            ca = p_a; cab = ca + p_b; cabc = cab + p_c;
            if (ch <= ca)
                ;
            else if (ch <= cab)
                dst_acc |= bitm;
            else if (ch <= cabc)
                src_acc |= bitm;
            else
            begin
                src_acc |= bitm;
                dst_acc |= bitm;
            end
        end
        e.src = src_acc;
        e.dst = dst_acc;
        if (lvl + 7'd1 >= sc)
        begin
            lvl = 0;
            return 1'b1;
        end
        lvl = lvl + 6'd1;
        return 1'b0;
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(0, 99) < 26);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [16:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_PROB_A: reg_a = val;
            REG_PROB_B: reg_b = val;
            REG_PROB_C: reg_c = val;
            REG_PROB_D: reg_d = val;
            REG_SCALE:  reg_scale = val[5:0];
            default: ;
        endcase
    endtask

    // valid stays high between back-to-back words; it drops only to idle or in drain
    task automatic send_level(input level_row_t r);
        edge_t e;
        if (idle_now())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (idle_now())
                @(posedge clk);
        end
        in_valid     <= 1'b1;
        noise_a      <= r.na;
        noise_b      <= r.nb;
        noise_c      <= r.nc;
        noise_d      <= r.nd;
        choice_value <= r.ch;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (advance_level(r.na, r.nb, r.nc, r.nd, r.ch, e))
        begin
            edge_q.push_back(e);
            typed_flag_q.push_back(r.chk);
            typed_q.push_back('{src: r.src, dst: r.dst});
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (edge_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic level_row_t rand_row();
        level_row_t r;
        r.na = 16'($urandom); r.nb = 16'($urandom); r.nc = 16'($urandom);
        r.nd = 16'($urandom);
        r.ch = 16'($urandom);
        r.chk = 1'b0; r.src = '0; r.dst = '0;
        return r;
    endfunction

    // result side: random stall, compare against oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (edge_q.size() == 0)
                begin
                    $error("edge word with no prediction: src=%h dst=%h",
                           source_vertex, dest_vertex);
                    errors++;
                end
                else
                begin
                    if (source_vertex !== edge_q[0].src)
                    begin
                        $error("source_vertex expected %h actual %h",
                               edge_q[0].src, source_vertex);
                        errors++;
                    end
                    if (dest_vertex !== edge_q[0].dst)
                    begin
                        $error("dest_vertex expected %h actual %h",
                               edge_q[0].dst, dest_vertex);
                        errors++;
                    end
                    if (typed_flag_q[0] && (typed_q[0] !== edge_q[0]))
                    begin
                        $error("table row expected src=%h dst=%h, model gives src=%h dst=%h",
                               typed_q[0].src, typed_q[0].dst, edge_q[0].src, edge_q[0].dst);
                        errors++;
                    end
                    void'(edge_q.pop_front());
                    void'(typed_q.pop_front());
                    void'(typed_flag_q.pop_front());
                end
            end
            out_ready <= !idle_now();
        end
    end

    // watchdog: cycles with no word accepted on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > 20000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0; out_ready = 1'b0; cfg_valid = 1'b0;
        noise_a = '0; noise_b = '0; noise_c = '0; noise_d = '0; choice_value = '0;
        cfg_index = '0; cfg_data = '0;
        calm = 1'b0;
        reg_a = 36045; reg_b = 6554; reg_c = 6554; reg_d = 16383; reg_scale = 20;
        lvl = 0; src_acc = 0; dst_acc = 0;
        p_a = reg_a; p_b = reg_b; p_c = reg_c; p_d = reg_d;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // scale 1: one word per edge; quadrant picks read off directly
        write_reg(REG_SCALE, 17'd1);
        dir_rows = '{
            '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0,     1'b1, 32'd0, 32'd0},
            '{16'd0,    16'd0,    16'd0,    16'd0,    16'd36045, 1'b1, 32'd0, 32'd0},
            '{16'd0,    16'd0,    16'd0,    16'd0,    16'd36046, 1'b1, 32'd0, 32'd1},
            '{16'd0,    16'd0,    16'd0,    16'd0,    16'd42600, 1'b1, 32'd1, 32'd0},
            '{16'd0,    16'd0,    16'd0,    16'd0,    16'hFFFF,  1'b1, 32'd1, 32'd1}
        };
        foreach (dir_rows[i])
            send_level(dir_rows[i]);
        drain();

        // all-zero probabilities: zero sum path, choice zero vs nonzero
        write_reg(REG_PROB_A, 17'd0); write_reg(REG_PROB_B, 17'd0);
        write_reg(REG_PROB_C, 17'd0); write_reg(REG_PROB_D, 17'd0);
        write_reg(REG_SCALE, 17'd3);
        dir_rows = '{
            '{16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 1'b1, 32'd0, 32'd0},
            '{16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 1'b0, 32'd0, 32'd0},
            '{16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 1'b1, 32'd0, 32'd0},
            '{16'd0, 16'd0, 16'd0, 16'd0, 16'd1,    1'b0, 32'd0, 32'd0},
            '{16'd0, 16'd0, 16'd0, 16'd0, 16'd5,    1'b0, 32'd0, 32'd0},
            '{16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b1, 32'd7, 32'd7}
        };
        foreach (dir_rows[i])
            send_level(dir_rows[i]);
        drain();

        // saturated registers, scale 0 and above the maximum
        write_reg(REG_PROB_A, 17'h1FFFF); write_reg(REG_PROB_B, 17'h10000);
        write_reg(REG_PROB_C, 17'h1FFFF); write_reg(REG_PROB_D, 17'h10000);
        write_reg(REG_SCALE, 17'd0);
        send_level('{16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b0, 32'd0, 32'd0});
        send_level('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0,    1'b1, 32'd0, 32'd0});
        drain();
        write_reg(REG_SCALE, 17'h3F);
        for (n = 0; n < 32; n++)
            send_level(rand_row());
        drain();

        // scale lowered mid-edge ends the edge at the next word
        write_reg(REG_SCALE, 17'd8);
        for (n = 0; n < 5; n++)
            send_level(rand_row());
        drain();
        write_reg(REG_SCALE, 17'd3);
        send_level(rand_row());
        drain();

        // random phases with varied settings
        for (int ph = 0; ph < 40; ph++)
        begin
            calm = (ph >= 15 && ph < 20);
            write_reg(REG_PROB_A, (ph % 9 == 0) ? 17'h10000 : 17'($urandom_range(0, 131071)));
            write_reg(REG_PROB_B, 17'($urandom_range(0, 65536)));
            write_reg(REG_PROB_C, 17'($urandom_range(0, 65536)));
            write_reg(REG_PROB_D, (ph % 7 == 0) ? 17'd0 : 17'($urandom_range(0, 131071)));
            write_reg(REG_SCALE, (ph % 10 == 3) ? 17'd32 : 17'($urandom_range(1, 8)));
            for (n = 0; n < 48; n++)
                send_level(rand_row());
            drain();
        end
        calm = 1'b0;

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/rmat_pkg.sv
hw/rtl/rmat_div.sv
hw/rtl/rmat_edge_generator.sv
hw/rtl/rmat_checker.sv
bench/tb_rmat_edge_generator.sv
